// ===== rtl/fpld_pkg.sv =====
// ----------------------------------------------------------------------------
// fpld_pkg
// Shared types and constants for the four-pin lockout debounce block.
// ----------------------------------------------------------------------------
package fpld_pkg;

    // Pin order, also the order in which events leave the block
    localparam int unsigned PIN_DOOR   = 0;
    localparam int unsigned PIN_LOCK   = 1;
    localparam int unsigned PIN_RELOAD = 2;
    localparam int unsigned PIN_SHUT   = 3;
    localparam int unsigned NUM_PINS   = 4;

    localparam int unsigned WINDOW_W = 16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd20;

    // Event codes
    typedef enum logic [2:0] {
        EV_DOOR_OPENED   = 3'd0,
        EV_DOOR_CLOSED   = 3'd1,
        EV_LOCK_CONFIRM  = 3'd2,
        EV_LOCK_RELEASE  = 3'd3,
        EV_RELOAD_REQ    = 3'd4,
        EV_SHUTDOWN_REQ  = 3'd5,
        EV_SHUTDOWN_END  = 3'd6
    } t_event_code;

    // Item function codes
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

    // Debounced status as reported with every result
    typedef struct packed {
        logic door_closed;
        logic lock_confirmed;
        logic reload_requested;
        logic shutdown_requested;
    } t_fpld_status;

    // One classified item between the front and back parts
    typedef struct packed {
        logic [NUM_PINS-1:0]  ev;     // event pending per pin
        t_event_code [NUM_PINS-1:0] code;
        t_fpld_status         status;
    } t_fpld_entry;

endpackage

// ===== rtl/fpld_front.sv =====
// ----------------------------------------------------------------------------
// fpld_front
// Holds the debounce state, takes one item per cycle when accepted and classifies
// it into a per-pin event set plus the debounced status.
// ----------------------------------------------------------------------------
module fpld_front #(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fpld_pkg::WINDOW_W-1:0]   i_cfg_wdata,
    input  logic                            i_accept,
    input  logic                            i_func,
    input  logic [fpld_pkg::NUM_PINS-1:0]   i_raw,
    input  logic [31:0]                     i_tick_now,
    output fpld_pkg::t_fpld_entry           o_entry
);
    import fpld_pkg::*;

    logic [WINDOW_W-1:0]    r_window;
    logic [NUM_PINS-1:0]    r_level;
    logic [TICK_WIDTH-1:0]  r_time [NUM_PINS];

    logic [NUM_PINS-1:0]    n_level;
    logic [NUM_PINS-1:0]    chg;
    logic [TICK_WIDTH-1:0]  now;
    logic [TICK_WIDTH-1:0]  elapsed [NUM_PINS];

    assign now = TICK_WIDTH'(i_tick_now);

    // Lockout check per pin, wrap-around elapsed time
    always_comb begin
        for (int p = 0; p < NUM_PINS; p++) begin
            elapsed[p] = now - r_time[p];
            chg[p]     = (i_func == FUNC_POLL) && (elapsed[p] >= TICK_WIDTH'(r_window))
                         && (i_raw[p] != r_level[p]);
        end
        n_level = (i_func == FUNC_SEED) ? i_raw : ((r_level & ~chg) | (i_raw & chg));
    end

    // Classification: events only for accepted changes, reload on press only
    always_comb begin
        o_entry.ev[PIN_DOOR]     = chg[PIN_DOOR];
        o_entry.ev[PIN_LOCK]     = chg[PIN_LOCK];
        o_entry.ev[PIN_RELOAD]   = chg[PIN_RELOAD] && !i_raw[PIN_RELOAD];
        o_entry.ev[PIN_SHUT]     = chg[PIN_SHUT];
        o_entry.code[PIN_DOOR]   = i_raw[PIN_DOOR] ? EV_DOOR_OPENED : EV_DOOR_CLOSED;
        o_entry.code[PIN_LOCK]   = i_raw[PIN_LOCK] ? EV_LOCK_CONFIRM : EV_LOCK_RELEASE;
        o_entry.code[PIN_RELOAD] = EV_RELOAD_REQ;
        o_entry.code[PIN_SHUT]   = i_raw[PIN_SHUT] ? EV_SHUTDOWN_END : EV_SHUTDOWN_REQ;
        o_entry.status.door_closed        = !n_level[PIN_DOOR];
        o_entry.status.lock_confirmed     = n_level[PIN_LOCK];
        o_entry.status.reload_requested   = !n_level[PIN_RELOAD];
        o_entry.status.shutdown_requested = !n_level[PIN_SHUT];
    end

    // Window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Levels and change timestamps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 4'b1100;
            for (int p = 0; p < NUM_PINS; p++) r_time[p] <= '0;
        end else if (i_accept) begin
            r_level <= n_level;
            for (int p = 0; p < NUM_PINS; p++) begin
                if (i_func == FUNC_SEED) begin
                    r_time[p] <= '0;
                end else if (chg[p]) begin
                    r_time[p] <= now;
                end
            end
        end
    end

endmodule

// ===== rtl/fpld_fifo.sv =====
// ----------------------------------------------------------------------------
// fpld_fifo
// Short show-ahead queue of classified items between front and back.
// ----------------------------------------------------------------------------
module fpld_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  fpld_pkg::t_fpld_entry   i_data,
    output logic                    o_full,
    input  logic                    i_pop,
    output fpld_pkg::t_fpld_entry   o_data,
    output logic                    o_empty
);
    import fpld_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_fpld_entry        r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/fpld_back.sv =====
// ----------------------------------------------------------------------------
// fpld_back
// Drains the queue head into the output register, one result per cycle unless
// stalled: one per pending event in pin order, or one status-only result.
// ----------------------------------------------------------------------------
module fpld_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fpld_pkg::t_fpld_entry               i_head,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_event_valid,
    output logic [2:0]                          o_event_code,
    output logic                                o_last_event,
    output fpld_pkg::t_fpld_status              o_status
);
    import fpld_pkg::*;

    logic [NUM_PINS-1:0]    r_sent;
    logic                   r_out_valid;
    logic                   r_event_valid;
    logic [2:0]             r_event_code;
    logic                   r_last_event;
    t_fpld_status           r_status;

    logic [NUM_PINS-1:0]    rem;
    logic [NUM_PINS-1:0]    pick;
    logic [NUM_PINS-1:0]    n_rem;
    logic [1:0]             idx;
    logic                   load;

    // Lowest pending pin goes first
    always_comb begin
        rem  = i_head.ev & ~r_sent;
        pick = rem & (~rem + NUM_PINS'(1));
        idx  = '0;
        for (int k = NUM_PINS - 1; k >= 0; k--) begin
            if (rem[k]) idx = 2'(k);
        end
        n_rem = rem & ~pick;
        load  = !i_empty && (!r_out_valid || !i_out_stall);
        o_pop = load && (n_rem == '0);
    end

    // Progress through the head item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= '0;
        end else if (load) begin
            r_sent <= (n_rem == '0) ? '0 : (r_sent | pick);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_event_valid <= (rem != '0);
            r_event_code  <= (rem != '0) ? i_head.code[idx] : EV_DOOR_OPENED;
            r_last_event  <= (n_rem == '0);
            r_status      <= i_head.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_event_valid;
    assign o_event_code  = r_event_code;
    assign o_last_event  = r_last_event;
    assign o_status      = r_status;

    // A status-only result always closes its item and carries code zero
    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_event_valid) |-> (r_last_event && r_event_code == EV_DOOR_OPENED))
        else $error("status-only result malformed");

    // Pins already sent belong to the head item
    a_sent_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty) |-> ((r_sent & ~i_head.ev) == '0))
        else $error("sent mask outside head events");

    // The head is popped only on its last result
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_last_event))
        else $error("pop without last result");

    // Partial progress only while an item is in the queue
    a_sent_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sent != '0) |-> !i_empty)
        else $error("progress bits set with empty queue");

endmodule

// ===== rtl/four_pin_lockout_debounce_events.sv =====
// ----------------------------------------------------------------------------
// four_pin_lockout_debounce_events
// Lockout debounce on four pins with serialized event output.
// Accepted items are queued; each result is then registered in the output register.
// One item per clock in unless stalled; out: one result per event, or one if none.
// The two-entry item queue between classifier and output sets how far input runs ahead.
// Reset: levels door 0, lock 0, reload 1, shutdown 1; timestamps zero; window 20 ticks.
// ----------------------------------------------------------------------------
module four_pin_lockout_debounce_events #(
    parameter int unsigned TICK_WIDTH  = 32,
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic        i_door_level,
    input  logic        i_lock_level,
    input  logic        i_reload_level,
    input  logic        i_shutdown_level,
    input  logic [31:0] i_tick_now,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_event_valid,
    output logic [2:0]  o_event_code,
    output logic        o_last_event,
    output logic        o_door_closed,
    output logic        o_lock_confirmed,
    output logic        o_reload_requested,
    output logic        o_shutdown_requested
);
    import fpld_pkg::*;

    t_fpld_entry            front_entry;
    t_fpld_entry            head_entry;
    t_fpld_status           status;
    logic                   full;
    logic                   empty;
    logic                   pop;
    logic                   accept;
    logic [NUM_PINS-1:0]    raw;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;
    assign raw        = {i_shutdown_level, i_reload_level, i_lock_level, i_door_level};

    // Classifier and debounce state
    fpld_front #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_raw       (raw),
        .i_tick_now  (i_tick_now),
        .o_entry     (front_entry)
    );

    // Item queue
    fpld_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_empty (empty)
    );

    // Event serializer
    fpld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_entry),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_valid (o_event_valid),
        .o_event_code  (o_event_code),
        .o_last_event  (o_last_event),
        .o_status      (status)
    );

    assign o_door_closed        = status.door_closed;
    assign o_lock_confirmed     = status.lock_confirmed;
    assign o_reload_requested   = status.reload_requested;
    assign o_shutdown_requested = status.shutdown_requested;

endmodule
